FILE: rtl/core/variable_record_byte_fifo_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the variable record byte FIFO
// Concurrent checks sampled on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_BYTE_FIFO_CORE_MACROS_SVH
`define VARIABLE_RECORD_BYTE_FIFO_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define VRBF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define VRBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vrbf_pkg.sv
// ----------------------------------------------------------------------------
// vrbf_pkg
// Types and constants shared by the variable record byte FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vrbf_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 9;
    localparam int SUM_W  = LEN_W + 1;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_DRAIN   = 2'd1,
        CMD_DISCARD = 2'd2,
        CMD_CLEAR   = 2'd3
    } vrbf_cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_IGNORED  = 2'd3
    } vrbf_status_t;

    typedef struct packed {
        vrbf_cmd_t          command;
        logic [DATA_W-1:0]  data;
        logic               first_byte;
        logic [LEN_W-1:0]   record_length;
    } vrbf_in_t;

    typedef struct packed {
        vrbf_status_t       status;
        logic [DATA_W-1:0]  byte_out;
        logic               record_end;
        logic [LEN_W-1:0]   free_bytes;
        logic [LEN_W-1:0]   record_count;
    } vrbf_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/vrbf_ram.sv
// ----------------------------------------------------------------------------
// vrbf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module vrbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vrbf_ring.sv
// ----------------------------------------------------------------------------
// vrbf_ring
// Ring state, record stores and the update applied for each item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "variable_record_byte_fifo_core_macros.svh"

module vrbf_ring
    import vrbf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire vrbf_in_t  item,
    output vrbf_out_t      result
);

    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] gap_reg, gap_next;
    logic              full_reg, full_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [LEN_W-1:0]  hr_reg, hr_next;
    logic [LEN_W-1:0]  prem_reg, prem_next;
    logic              len_fwd_reg, len_fwd_next;
    logic [LEN_W-1:0]  len_fwd_data_reg;
    logic              byte_fwd_reg, byte_fwd_next;
    logic [DATA_W-1:0] byte_fwd_data_reg;

    logic              len_we, byte_we;
    logic [ADDR_W-1:0] len_waddr, byte_waddr, byte_raddr;
    logic [LEN_W-1:0]  len_rdata;
    logic [DATA_W-1:0] byte_rdata;
    logic [LEN_W-1:0]  head_len;
    logic [DATA_W-1:0] head_byte;

    logic              empty_ring, len_bad, fits_end, fits_front, fits_behind;
    logic              wrap_start;
    logic [ADDR_W-1:0] rp_al, wp_al, start_pos, wp_new;
    logic [SUM_W-1:0]  ret_sum;
    logic              ret_wrap;
    logic [ADDR_W-1:0] ret_rp;
    logic [LEN_W-1:0]  hr_eff, hr_dec;
    logic [CNT_W-1:0]  free_next;

    vrbf_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_len_ram (
        .aclk    (aclk),
        .wr_en   (len_we),
        .wr_addr (len_waddr),
        .wr_data (item.record_length),
        .rd_addr (rp_next),
        .rd_data (len_rdata)
    );

    vrbf_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_byte_ram (
        .aclk    (aclk),
        .wr_en   (byte_we),
        .wr_addr (byte_waddr),
        .wr_data (item.data),
        .rd_addr (byte_raddr),
        .rd_data (byte_rdata)
    );

    // The stores read the old word on a same-address write, so the new
    // word is carried over in a register instead.
    assign head_len  = len_fwd_reg  ? len_fwd_data_reg  : len_rdata;
    assign head_byte = byte_fwd_reg ? byte_fwd_data_reg : byte_rdata;

    assign empty_ring  = (rp_reg == wp_reg) && !full_reg;
    assign rp_al       = empty_ring ? '0 : rp_reg;
    assign wp_al       = empty_ring ? '0 : wp_reg;
    assign len_bad     = (item.record_length == '0)
                      || (item.record_length > LEN_W'(DEPTH)) || full_reg;
    assign fits_end    = (SUM_W'(wp_al) + SUM_W'(item.record_length)) <= SUM_W'(DEPTH);
    assign fits_front  = item.record_length <= LEN_W'(rp_al);
    assign fits_behind = item.record_length <= LEN_W'(rp_reg - wp_reg);
    assign wrap_start  = (wp_al >= rp_al) && !fits_end;
    assign start_pos   = wrap_start ? '0 : wp_al;
    assign wp_new      = ADDR_W'(SUM_W'(start_pos) + SUM_W'(item.record_length));

    assign ret_sum  = SUM_W'(rp_reg) + SUM_W'(head_len);
    assign ret_wrap = ret_sum >= SUM_W'(CNT_W'(DEPTH) - CNT_W'(gap_reg));
    assign ret_rp   = ret_wrap ? '0 : ADDR_W'(ret_sum);
    assign hr_eff   = (hr_reg == '0) ? head_len : hr_reg;
    assign hr_dec   = hr_eff - LEN_W'(1);

    always_comb begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        gap_next   = gap_reg;
        full_next  = full_reg;
        held_next  = held_reg;
        hr_next    = hr_reg;
        prem_next  = prem_reg;
        len_we     = 1'b0;
        len_waddr  = start_pos;
        byte_we    = 1'b0;
        byte_waddr = wp_reg - ADDR_W'(prem_reg);
        result     = '0;
        result.status = ST_OK;

        if (advance) begin
            unique case (item.command)
                CMD_PUSH: begin
                    if (prem_reg != '0) begin
                        byte_we   = 1'b1;
                        prem_next = prem_reg - LEN_W'(1);
                        if (prem_reg == LEN_W'(1)) begin
                            held_next = held_reg + CNT_W'(1);
                        end
                    end else if (!item.first_byte) begin
                        result.status = ST_IGNORED;
                    end else begin
                        rp_next  = rp_al;
                        wp_next  = wp_al;
                        gap_next = empty_ring ? '0 : gap_reg;
                        if (len_bad || ((wp_al >= rp_al) && !fits_end && !fits_front)
                                || ((wp_al < rp_al) && !fits_behind)) begin
                            result.status = ST_NO_SPACE;
                        end else begin
                            if (wrap_start) begin
                                gap_next = ADDR_W'(CNT_W'(DEPTH) - CNT_W'(wp_al));
                            end
                            len_we     = 1'b1;
                            byte_we    = 1'b1;
                            byte_waddr = start_pos;
                            wp_next    = wp_new;
                            full_next  = (wp_new == rp_al);
                            prem_next  = item.record_length - LEN_W'(1);
                            if (item.record_length == LEN_W'(1)) begin
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                CMD_DRAIN: begin
                    if (held_reg == '0) begin
                        result.status = ST_EMPTY;
                    end else begin
                        result.byte_out = head_byte;
                        hr_next         = hr_dec;
                        if (hr_dec == '0) begin
                            result.record_end = 1'b1;
                            rp_next   = ret_rp;
                            gap_next  = ret_wrap ? '0 : gap_reg;
                            full_next = 1'b0;
                            held_next = held_reg - CNT_W'(1);
                        end
                    end
                end
                CMD_DISCARD: begin
                    if (held_reg == '0) begin
                        result.status = ST_EMPTY;
                    end else begin
                        rp_next   = ret_rp;
                        gap_next  = ret_wrap ? '0 : gap_reg;
                        full_next = 1'b0;
                        held_next = held_reg - CNT_W'(1);
                        hr_next   = '0;
                    end
                end
                CMD_CLEAR: begin
                    rp_next   = '0;
                    wp_next   = '0;
                    gap_next  = '0;
                    full_next = 1'b0;
                    held_next = '0;
                    hr_next   = '0;
                    prem_next = '0;
                end
                default: begin
                    result.status = ST_OK;
                end
            endcase
        end

        if (full_next) begin
            free_next = '0;
        end else if (wp_next == rp_next) begin
            free_next = CNT_W'(DEPTH);
        end else if (wp_next > rp_next) begin
            free_next = CNT_W'(DEPTH) - CNT_W'(wp_next) + CNT_W'(rp_next);
        end else begin
            free_next = CNT_W'(rp_next) - CNT_W'(wp_next);
        end
        result.free_bytes   = LEN_W'(free_next);
        result.record_count = LEN_W'(held_next);

        // While a record is partly drained the head stays put and its
        // length is already known.
        byte_raddr    = (hr_next == '0) ? rp_next : rp_reg + ADDR_W'(head_len - hr_next);
        len_fwd_next  = len_we && (len_waddr == rp_next);
        byte_fwd_next = byte_we && (byte_waddr == byte_raddr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg       <= '0;
            wp_reg       <= '0;
            gap_reg      <= '0;
            full_reg     <= 1'b0;
            held_reg     <= '0;
            hr_reg       <= '0;
            prem_reg     <= '0;
            len_fwd_reg  <= 1'b0;
            byte_fwd_reg <= 1'b0;
        end else begin
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            gap_reg      <= gap_next;
            full_reg     <= full_next;
            held_reg     <= held_next;
            hr_reg       <= hr_next;
            prem_reg     <= prem_next;
            len_fwd_reg  <= len_fwd_next;
            byte_fwd_reg <= byte_fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_fwd_data_reg  <= item.record_length;
        byte_fwd_data_reg <= item.data;
    end

    `VRBF_ASSERT_IMPLY(a_full_meets, full_reg, rp_reg == wp_reg, "Full ring with split positions.")
    `VRBF_ASSERT_IMPLY(a_gap_order, gap_reg != '0, wp_reg <= rp_reg, "Gap with write ahead of read.")
    `VRBF_ASSERT_IMPLY(a_held_space, held_reg != '0, full_reg || (rp_reg != wp_reg),
        "Records held in an empty ring.")
    `VRBF_ASSERT_IMPLY(a_head_held, hr_reg != '0, held_reg != '0, "Head drain with no record.")
    `VRBF_ASSERT_NEXT(a_clear_zero, advance && (item.command == CMD_CLEAR),
        (held_reg == '0) && (hr_reg == '0) && (prem_reg == '0), "Clear left state behind.")

endmodule

`default_nettype wire

FILE: rtl/core/variable_record_byte_fifo_core.sv
// ----------------------------------------------------------------------------
// variable_record_byte_fifo_core
// Ring buffer of byte records of varying length, never split at the ring end.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake            Payload
//   s_        in          s_valid / s_ready    vrbf_in_t  (command, byte, length)
//   m_        out         m_valid / m_ready    vrbf_out_t (status, byte, counts)
//
// An item waits in the input register and leaves the ring update in the output
// register. While results are not stalled, one item is taken per cycle, bounded
// by one write and one read per store.
// Reset is synchronous and active low; the stores themselves are not cleared.
// A stalled result holds the input register; input is taken while the
// input register is empty or its item moves on to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_record_byte_fifo_core
    import vrbf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire vrbf_in_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output vrbf_out_t      m_payload
);

    logic      in_valid_reg, in_valid_next;
    vrbf_in_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    vrbf_out_t out_item_reg;
    logic      advance;
    vrbf_out_t ring_result;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    vrbf_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .result  (ring_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
        if (advance) begin
            out_item_reg <= ring_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_item_reg;

endmodule

`default_nettype wire

FILE: tb/sv/variable_record_byte_fifo_core_test.sv
// ----------------------------------------------------------------------------
// variable_record_byte_fifo_core_test
// Self-checking bench for the variable record byte FIFO. Items go in through
// a valid/ready channel with random gaps, and results are taken with random
// stalls and one long hold-off. Each accepted item is run through a local ring
// predictor, and every result is compared field by field with the oldest
// predicted reply. Directed cases cover the errors and the empty, gap and full
// ring states. A long random run of records, drains, discards and clears
// follows.
// ----------------------------------------------------------------------------
module variable_record_byte_fifo_core_test
    import vrbf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 840;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    vrbf_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    vrbf_out_t m_payload;

    logic [DATA_W-1:0] ring_bytes [DEPTH];
    logic [LEN_W-1:0]  ring_lengths [DEPTH];
    int unsigned       rd_pos = 0;
    int unsigned       wr_pos = 0;
    int unsigned       gap_len = 0;
    bit                ring_full = 1'b0;
    int unsigned       records_done = 0;
    int unsigned       head_left = 0;
    int unsigned       push_left = 0;

    vrbf_out_t ring_replies_due [$];
    vrbf_out_t due;
    int        error_count = 0;
    int        items_sent = 0;
    int        in_gap_max = 8;
    int        out_gap_max = 8;
    int        receiver_hold = 0;

    variable_record_byte_fifo_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned ring_free();
        if (ring_full) return 0;
        if (wr_pos == rd_pos) return DEPTH;
        if (wr_pos > rd_pos) return DEPTH - wr_pos + rd_pos;
        return rd_pos - wr_pos;
    endfunction

    function automatic void retire_head();
        int unsigned nxt;
        nxt = rd_pos + ring_lengths[rd_pos];
        if (nxt >= DEPTH - gap_len) begin
            nxt = 0;
            gap_len = 0;
        end
        rd_pos = nxt % DEPTH;
        ring_full = 1'b0;
        head_left = 0;
        if (records_done > 0) records_done--;
    endfunction

    function automatic void store_byte(input logic [DATA_W-1:0] value);
        ring_bytes[(wr_pos + DEPTH - (push_left % DEPTH)) % DEPTH] = value;
        push_left--;
        if (push_left == 0) records_done++;
    endfunction

    function automatic vrbf_status_t push_into_ring(input logic [DATA_W-1:0] value,
                                                   input logic first,
                                                   input int unsigned len);
        int unsigned start;
        if (push_left > 0) begin
            store_byte(value);
            return ST_OK;
        end
        if (!first) return ST_IGNORED;
        if (rd_pos == wr_pos && !ring_full) begin
            rd_pos = 0;
            wr_pos = 0;
            gap_len = 0;
        end
        if (len == 0 || len > DEPTH || ring_full) return ST_NO_SPACE;
        if (wr_pos >= rd_pos) begin
            if (wr_pos + len <= DEPTH) begin
                start = wr_pos;
            end else if (len <= rd_pos) begin
                gap_len = DEPTH - wr_pos;
                start = 0;
            end else begin
                return ST_NO_SPACE;
            end
        end else begin
            if (len > rd_pos - wr_pos) return ST_NO_SPACE;
            start = wr_pos;
        end
        ring_lengths[start] = LEN_W'(len);
        wr_pos = (start + len) % DEPTH;
        ring_full = (wr_pos == rd_pos);
        push_left = len;
        store_byte(value);
        return ST_OK;
    endfunction

    function automatic vrbf_out_t ring_next_reply(input vrbf_in_t item);
        vrbf_out_t   reply;
        int unsigned rlen;
        reply = '0;
        case (item.command)
            CMD_PUSH: begin
                reply.status = push_into_ring(item.data, item.first_byte, item.record_length);
            end
            CMD_DRAIN: begin
                if (records_done == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    rlen = ring_lengths[rd_pos];
                    if (head_left == 0) head_left = rlen;
                    reply.byte_out = ring_bytes[(rd_pos + rlen - head_left) % DEPTH];
                    head_left--;
                    if (head_left == 0) begin
                        reply.record_end = 1'b1;
                        retire_head();
                    end
                end
            end
            CMD_DISCARD: begin
                if (records_done == 0) reply.status = ST_EMPTY;
                else retire_head();
            end
            default: begin
                rd_pos = 0;
                wr_pos = 0;
                gap_len = 0;
                ring_full = 1'b0;
                records_done = 0;
                head_left = 0;
                push_left = 0;
            end
        endcase
        reply.free_bytes = LEN_W'(ring_free());
        reply.record_count = LEN_W'(records_done);
        return reply;
    endfunction

    task automatic send_item(input vrbf_cmd_t cmd, input logic [DATA_W-1:0] value,
                             input logic first, input logic [LEN_W-1:0] len);
        int       idle;
        vrbf_in_t item;
        idle = $urandom_range(0, in_gap_max);
        item = '{command: cmd, data: value, first_byte: first, record_length: len};
        @(negedge aclk);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
        ring_replies_due.push_back(ring_next_reply(item));
        items_sent++;
    endtask

    task automatic send_command(input vrbf_cmd_t cmd);
        send_item(cmd, DATA_W'($urandom), 1'($urandom), LEN_W'($urandom));
    endtask

    task automatic send_record(input int len, input bit stray_flags);
        send_item(CMD_PUSH, DATA_W'($urandom), 1'b1, LEN_W'(len));
        for (int k = 1; k < len; k++) begin
            send_item(CMD_PUSH, DATA_W'($urandom), stray_flags && ($urandom_range(0, 15) == 0),
                      LEN_W'($urandom));
        end
    endtask

    function automatic int record_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(1, 8);
        if (roll < 85) return $urandom_range(9, 64);
        if (roll < 97) return $urandom_range(65, 200);
        return $urandom_range(255, 256);
    endfunction

    task automatic wait_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ring_replies_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string field, input logic [LEN_W-1:0] want,
                               input logic [LEN_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (ring_replies_due.size() == 0) begin
                $error("result with no item outstanding: %p", m_payload);
                error_count++;
            end else begin
                due = ring_replies_due.pop_front();
                check_field("status", LEN_W'(due.status), LEN_W'(m_payload.status));
                check_field("byte_out", LEN_W'(due.byte_out), LEN_W'(m_payload.byte_out));
                check_field("record_end", LEN_W'(due.record_end),
                            LEN_W'(m_payload.record_end));
                check_field("free_bytes", due.free_bytes, m_payload.free_bytes);
                check_field("record_count", due.record_count, m_payload.record_count);
            end
        end
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                stall = receiver_hold;
                receiver_hold = 0;
            end else begin
                stall = $urandom_range(0, out_gap_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic test_empty_and_errors();
        send_command(CMD_DRAIN);
        send_command(CMD_DISCARD);
        send_item(CMD_PUSH, 8'hFF, 1'b0, 9'd4);
        send_item(CMD_PUSH, 8'h11, 1'b1, 9'd0);
        send_item(CMD_PUSH, 8'h22, 1'b0, 9'd0);
        send_item(CMD_PUSH, 8'h33, 1'b1, 9'd257);
        send_item(CMD_PUSH, 8'h44, 1'b1, 9'h1FF);
        send_item(CMD_PUSH, 8'h00, 1'b1, 9'd1);
        send_item(CMD_PUSH, 8'hFF, 1'b1, 9'd2);
        send_item(CMD_PUSH, 8'hA5, 1'b1, 9'd5);
        send_command(CMD_DRAIN);
        send_command(CMD_DRAIN);
        send_command(CMD_DRAIN);
        send_command(CMD_DRAIN);
        send_item(CMD_PUSH, 8'h01, 1'b1, 9'd3);
        send_item(CMD_PUSH, 8'h02, 1'b0, 9'd0);
        send_item(CMD_PUSH, 8'h03, 1'b0, 9'd0);
        send_command(CMD_DRAIN);
        send_command(CMD_DISCARD);
        send_item(CMD_PUSH, 8'h5A, 1'b1, 9'd2);
        send_command(CMD_CLEAR);
        send_item(CMD_PUSH, 8'h66, 1'b0, 9'd2);
        send_command(CMD_DISCARD);
        send_command(CMD_CLEAR);
        wait_until_drained();
    endtask

    task automatic test_gap_and_full_ring();
        send_record(120, 1'b0);
        send_record(120, 1'b0);
        send_command(CMD_DISCARD);
        send_record(20, 1'b0);
        send_record(100, 1'b0);
        send_item(CMD_PUSH, DATA_W'($urandom), 1'b1, 9'd1);
        send_item(CMD_PUSH, DATA_W'($urandom), 1'b0, 9'd1);
        send_command(CMD_DISCARD);
        repeat (23) send_command(CMD_DRAIN);
        send_command(CMD_DISCARD);
        send_record(DEPTH, 1'b0);
        send_item(CMD_PUSH, DATA_W'($urandom), 1'b1, 9'd1);
        repeat (2) send_command(CMD_DRAIN);
        send_command(CMD_DISCARD);
        wait_until_drained();
    endtask

    task automatic test_backpressure();
        in_gap_max = 0;
        receiver_hold = HOLD_CYCLES;
        repeat (4) begin
            send_record(6, 1'b0);
            repeat (3) send_command(CMD_DRAIN);
        end
        wait_until_drained();
        in_gap_max = 8;
    endtask

    task automatic test_random_traffic();
        int pick;
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 5) begin
                in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
                out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_record(record_size(), $urandom_range(0, 7) == 0);
            end else if (pick < 38) begin
                case ($urandom_range(0, 3))
                    0: send_item(CMD_PUSH, DATA_W'($urandom), 1'b1, 9'd0);
                    1: send_item(CMD_PUSH, DATA_W'($urandom), 1'b1,
                                 LEN_W'($urandom_range(DEPTH + 1, 511)));
                    2: send_item(CMD_PUSH, DATA_W'($urandom), 1'b0, LEN_W'($urandom));
                    default: send_record($urandom_range(1, 4), 1'b1);
                endcase
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 12)) send_command(CMD_DRAIN);
            end else if (pick < 98) begin
                send_command(CMD_DISCARD);
            end else begin
                send_command(CMD_CLEAR);
            end
        end
        wait_until_drained();
    endtask

    initial begin : test_sequence
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_and_errors();
        test_gap_and_full_ring();
        test_backpressure();
        test_random_traffic();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : run_limit
        #RUN_LIMIT_NS;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: variable_record_byte_fifo_core.f
+incdir+rtl/core
rtl/core/vrbf_pkg.sv
rtl/core/vrbf_ram.sv
rtl/core/vrbf_ring.sv
rtl/core/variable_record_byte_fifo_core.sv
tb/sv/variable_record_byte_fifo_core_test.sv
